/* hdl/sri_pkg.sv */
// ============================================================================
// sri_pkg: shared widths, types and helpers of the segment/rectangle test
// Coordinate widths, derived arithmetic widths, register codes and the small
// geometric helper functions used by the pipeline.
// ============================================================================
package sri_pkg;

    // Coordinate format and derived widths.
    localparam int COORD_BITS     = 22;
    localparam int SIZE_BITS      = COORD_BITS - 1;
    localparam int EXT_BITS       = COORD_BITS + 1;
    localparam int DIFF_BITS      = COORD_BITS + 2;
    localparam int PROD_BITS      = 2 * DIFF_BITS;
    localparam int CROSS_BITS     = PROD_BITS + 1;
    localparam int CROSS_TOL_BITS = 20;
    localparam int BOUND_TOL_BITS = 10;
    localparam int BOX_BITS       =
        ((EXT_BITS > BOUND_TOL_BITS + 1) ? EXT_BITS : BOUND_TOL_BITS + 1) + 1;
    localparam int MAG_BITS       =
        ((CROSS_BITS > CROSS_TOL_BITS) ? CROSS_BITS : CROSS_TOL_BITS) + 1;
    localparam int CFG_DATA_BITS  =
        (CROSS_TOL_BITS > BOUND_TOL_BITS) ? CROSS_TOL_BITS : BOUND_TOL_BITS;

    // Reset values of the tolerance registers.
    localparam logic [CROSS_TOL_BITS-1:0] CROSS_TOL_RESET = CROSS_TOL_BITS'(1049);
    localparam logic [BOUND_TOL_BITS-1:0] BOUND_TOL_RESET = BOUND_TOL_BITS'(1);

    // Four rectangle corners, and twelve orientation tests: one per corner
    // against the segment, then the segment start and end against each edge.
    localparam int N_CORNER = 4;
    localparam int N_ORIENT = 3 * N_CORNER;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [SIZE_BITS-1:0]  t_size;
    typedef logic signed [EXT_BITS-1:0]   t_ext;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic signed [CROSS_BITS-1:0] t_cross;
    typedef logic signed [BOX_BITS-1:0]   t_box;
    typedef logic [CROSS_TOL_BITS-1:0]    t_ctol;
    typedef logic [BOUND_TOL_BITS-1:0]    t_btol;
    typedef logic [CFG_DATA_BITS-1:0]     t_cfg_data;

    typedef enum logic [0:0] {
        CFG_CROSS_TOL = 1'b0,
        CFG_BOUND_TOL = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_ext x;
        t_ext y;
    } t_point;

    // Difference of two extended coordinates at full width.
    function automatic t_diff diff(input t_ext a, input t_ext b);
        return t_diff'(a) - t_diff'(b);
    endfunction

    // Point p inside the box of segment a-b, widened by tol on every side.
    function automatic logic in_box(input t_point a, input t_point b,
                                    input t_point p, input t_btol tol);
        t_box t;
        t_box lox;
        t_box hix;
        t_box loy;
        t_box hiy;
        t = $signed({{(BOX_BITS-BOUND_TOL_BITS){1'b0}}, tol});
        lox = (a.x < b.x) ? t_box'(a.x) : t_box'(b.x);
        hix = (a.x > b.x) ? t_box'(a.x) : t_box'(b.x);
        loy = (a.y < b.y) ? t_box'(a.y) : t_box'(b.y);
        hiy = (a.y > b.y) ? t_box'(a.y) : t_box'(b.y);
        return (t_box'(p.x) >= lox - t) && (t_box'(p.x) <= hix + t) &&
               (t_box'(p.y) >= loy - t) && (t_box'(p.y) <= hiy + t);
    endfunction

    // Magnitude of a cross product strictly below the tolerance.
    function automatic logic near_zero(input t_cross x, input t_ctol tol);
        logic [MAG_BITS-1:0] wx;
        logic [MAG_BITS-1:0] mag;
        wx  = MAG_BITS'(x);
        mag = x[CROSS_BITS-1] ? (~wx + MAG_BITS'(1)) : wx;
        return mag < MAG_BITS'(tol);
    endfunction

    function automatic logic is_pos(input t_cross x);
        return !x[CROSS_BITS-1] && (x != '0);
    endfunction

    // Strictly opposite signs, zero counting as neither.
    function automatic logic opposite(input t_cross p, input t_cross q);
        return (is_pos(p) && q[CROSS_BITS-1]) || (p[CROSS_BITS-1] && is_pos(q));
    endfunction

endpackage

/* hdl/sri_in_if.sv */
// ============================================================================
// sri_in_if: query channel of the segment/rectangle test
// Carries one segment and one rectangle per beat with valid/ready handshake.
// ============================================================================
interface sri_in_if
    import sri_pkg::*;
();
    logic   valid;
    logic   ready;
    t_coord start_x;
    t_coord start_y;
    t_coord end_x;
    t_coord end_y;
    t_coord rect_left;
    t_coord rect_top;
    t_size  rect_width;
    t_size  rect_height;

    modport source (
        output valid, start_x, start_y, end_x, end_y,
               rect_left, rect_top, rect_width, rect_height,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, end_x, end_y,
               rect_left, rect_top, rect_width, rect_height,
        output ready
    );
endinterface

/* hdl/sri_out_if.sv */
// ============================================================================
// sri_out_if: result channel of the segment/rectangle test
// Carries one hit flag per beat with valid/ready handshake.
// ============================================================================
interface sri_out_if
    import sri_pkg::*;
();
    logic valid;
    logic ready;
    logic hit;

    modport source (
        output valid, hit,
        input  ready
    );

    modport sink (
        input  valid, hit,
        output ready
    );
endinterface

/* hdl/segment_rect_intersect.sv */
// ============================================================================
// segment_rect_intersect: segment versus axis-aligned rectangle hit test
// Throughput: one beat per cycle; the five register stages (input,
// operands, products, cross products, result) all advance together and
// hold only while the result register is full and not taken.
// Reset: synchronous active-low reset empties the pipeline and loads the
// default tolerances; no clearing pass is needed.
// ============================================================================
module segment_rect_intersect
    import sri_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  t_cfg_data   i_cfg_data,
    sri_in_if.sink      i_in,
    sri_out_if.source   o_out
);

    // Tolerance registers.
    t_ctol r_cross_tol;
    t_btol r_bound_tol;

    // Stage valid bits, one per register stage.
    logic [4:0] r_vld;
    logic       w_adv;

    // Stage 1: points and rectangle corners.
    t_point r_s1_s, r_s1_e;
    t_point r_s1_c [N_CORNER];
    t_point n_s1_c [N_CORNER];

    // Stage 2: multiplier operands and flags.
    t_diff r_s2_ma0 [N_ORIENT];
    t_diff r_s2_mb0 [N_ORIENT];
    t_diff r_s2_ma1 [N_ORIENT];
    t_diff r_s2_mb1 [N_ORIENT];
    t_diff n_s2_ma0 [N_ORIENT];
    t_diff n_s2_mb0 [N_ORIENT];
    t_diff n_s2_ma1 [N_ORIENT];
    t_diff n_s2_mb1 [N_ORIENT];
    logic [N_ORIENT-1:0] r_s2_box, n_s2_box;
    logic                r_s2_inside, n_s2_inside;

    // Stage 3: products.
    t_prod r_s3_p0 [N_ORIENT];
    t_prod r_s3_p1 [N_ORIENT];
    logic [N_ORIENT-1:0] r_s3_box;
    logic                r_s3_inside;

    // Stage 4: cross products.
    t_cross r_s4_x [N_ORIENT];
    logic [N_ORIENT-1:0] r_s4_box;
    logic                r_s4_inside;

    // Stage 5: result.
    logic r_hit, n_hit;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cross_tol <= CROSS_TOL_RESET;
            r_bound_tol <= BOUND_TOL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CROSS_TOL: r_cross_tol <= i_cfg_data[CROSS_TOL_BITS-1:0];
                CFG_BOUND_TOL: r_bound_tol <= i_cfg_data[BOUND_TOL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves unless the result register holds an untaken beat.
    assign w_adv       = !r_vld[4] || o_out.ready;
    assign i_in.ready  = w_adv;
    assign o_out.valid = r_vld[4];
    assign o_out.hit   = r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[3:0], i_in.valid};
        end
    end

    // Stage 1: far corner at full width; corners in edge order around the box.
    always_comb begin
        t_ext x0, y0, x1, y1;
        x0 = t_ext'(i_in.rect_left);
        y0 = t_ext'(i_in.rect_top);
        x1 = x0 + t_ext'({1'b0, i_in.rect_width});
        y1 = y0 + t_ext'({1'b0, i_in.rect_height});
        n_s1_c[0] = '{x: x0, y: y0};
        n_s1_c[1] = '{x: x1, y: y0};
        n_s1_c[2] = '{x: x1, y: y1};
        n_s1_c[3] = '{x: x0, y: y1};
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_s <= '{x: t_ext'(i_in.start_x), y: t_ext'(i_in.start_y)};
            r_s1_e <= '{x: t_ext'(i_in.end_x),   y: t_ext'(i_in.end_y)};
            r_s1_c <= n_s1_c;
        end
    end

    // Stage 2: operand differences, bounding-box flags and the endpoint test.
    // Tests 0..3 place each corner against the segment; tests 4+2k and 5+2k
    // place the segment start and end against edge k.
    always_comb begin
        t_point pa, pb, pc;
        int     ek;
        for (int j = 0; j < N_ORIENT; j++) begin
            if (j < N_CORNER) begin
                pa = r_s1_s;
                pb = r_s1_e;
                pc = r_s1_c[j];
            end else begin
                ek = (j - N_CORNER) >> 1;
                pa = r_s1_c[ek];
                pb = r_s1_c[(ek + 1) % N_CORNER];
                pc = ((j & 1) == 0) ? r_s1_s : r_s1_e;
            end
            n_s2_ma0[j] = diff(pb.x, pa.x);
            n_s2_mb0[j] = diff(pc.y, pa.y);
            n_s2_ma1[j] = diff(pb.y, pa.y);
            n_s2_mb1[j] = diff(pc.x, pa.x);
            n_s2_box[j] = in_box(pa, pb, pc, r_bound_tol);
        end
        n_s2_inside =
            (r_s1_s.x >= r_s1_c[0].x && r_s1_s.x <= r_s1_c[2].x &&
             r_s1_s.y >= r_s1_c[0].y && r_s1_s.y <= r_s1_c[2].y) ||
            (r_s1_e.x >= r_s1_c[0].x && r_s1_e.x <= r_s1_c[2].x &&
             r_s1_e.y >= r_s1_c[0].y && r_s1_e.y <= r_s1_c[2].y);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_ma0    <= n_s2_ma0;
            r_s2_mb0    <= n_s2_mb0;
            r_s2_ma1    <= n_s2_ma1;
            r_s2_mb1    <= n_s2_mb1;
            r_s2_box    <= n_s2_box;
            r_s2_inside <= n_s2_inside;
        end
    end

    // Stage 3: two registered products per orientation test. The operands
    // are sign-extended 24-bit differences, so the full product fits.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < N_ORIENT; j++) begin
                r_s3_p0[j] <= t_prod'(r_s2_ma0[j]) * t_prod'(r_s2_mb0[j]);
                r_s3_p1[j] <= t_prod'(r_s2_ma1[j]) * t_prod'(r_s2_mb1[j]);
            end
            r_s3_box    <= r_s2_box;
            r_s3_inside <= r_s2_inside;
        end
    end

    // Stage 4: cross products.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < N_ORIENT; j++) begin
                r_s4_x[j] <= t_cross'(r_s3_p0[j]) - t_cross'(r_s3_p1[j]);
            end
            r_s4_box    <= r_s3_box;
            r_s4_inside <= r_s3_inside;
        end
    end

    // Stage 5: per-edge crossing and touching tests, then the final hit.
    always_comb begin
        logic [N_ORIENT-1:0] nz;
        int                  kn;
        for (int j = 0; j < N_ORIENT; j++) begin
            nz[j] = near_zero(r_s4_x[j], r_cross_tol) && r_s4_box[j];
        end
        n_hit = r_s4_inside;
        for (int k = 0; k < N_CORNER; k++) begin
            kn = (k + 1) % N_CORNER;
            if ((opposite(r_s4_x[k], r_s4_x[kn]) &&
                 opposite(r_s4_x[N_CORNER + 2*k], r_s4_x[N_CORNER + 2*k + 1])) ||
                nz[k] || nz[kn] || nz[N_CORNER + 2*k] || nz[N_CORNER + 2*k + 1]) begin
                n_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hit <= n_hit;
        end
    end

    // Reset leaves the pipeline empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> r_vld == '0)
        else $error("pipeline not empty after reset");

    // A held pipeline keeps every stage's valid bit.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

    // An endpoint inside the rectangle always gives a hit.
    a_inside_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_vld[3] && r_s4_inside |=> r_hit)
        else $error("endpoint inside rectangle without hit");

    // A bound tolerance write lands in its register.
    a_cfg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && i_cfg_idx == CFG_BOUND_TOL
            |=> r_bound_tol == $past(i_cfg_data[BOUND_TOL_BITS-1:0]))
        else $error("bound tolerance write lost");

endmodule
